// ===== sv/mp5r_pkg.sv =====
`default_nettype none
package mp5r_pkg;

  // sample format and register widths
  localparam int SAMPLE_WIDTH = 32;
  localparam int GAIN_W       = 4;
  localparam int THR_W        = 16;
  localparam int PROD_W       = 2 * THR_W;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMITER_GAIN     = 2'd0,
    CFG_ACCEPT_THRESHOLD = 2'd1
  } cfg_idx_e;

  // working width for most intermediates of the limiter
  localparam int WIDE_W = SAMPLE_WIDTH + 8;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [WIDE_W-1:0]       wide_t;

  localparam wide_t WIDE_ZERO = '0;
  localparam wide_t COEF_M1   = 13;
  localparam wide_t COEF_C    = 47;
  localparam wide_t COEF_P1   = 27;
  localparam wide_t COEF_P2   = 3;
  localparam wide_t SAT_MAX   = {{(WIDE_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam wide_t SAT_MIN   = {{(WIDE_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  // rounded divide by 60: add 30, drop two bits, then divide by 15
  // split into hi/lo halves: m/15 = hi*Q15 + (hi*R15 + lo)/15
  localparam int DIV_W    = SAMPLE_WIDTH + 6;
  localparam int ROUND60  = 30;
  localparam int M4_W     = DIV_W - 2;
  localparam int LO_W     = M4_W / 2;
  localparam int HI_W     = M4_W - LO_W;
  localparam int X15_W    = HI_W + 4;
  localparam int S15      = X15_W + 4;
  localparam int K15_W    = S15 - 3;
  localparam int Q15_W    = LO_W - 3;
  localparam int P15H_W   = HI_W + Q15_W;
  localparam int P15X_W   = X15_W + K15_W;
  localparam logic [Q15_W-1:0] Q15 = Q15_W'((64'd1 << LO_W) / 64'd15);
  localparam logic [3:0]       R15 = 4'((64'd1 << LO_W) % 64'd15);
  localparam logic [K15_W-1:0] K15 = K15_W'(((64'd1 << S15) + 64'd14) / 64'd15);

  // rounded divide by 3, same split scheme
  localparam int DIV3_W   = SAMPLE_WIDTH + 4;
  localparam int L3       = DIV3_W / 2;
  localparam int HI3_W    = DIV3_W - L3;
  localparam int X3_W     = HI3_W + 2;
  localparam int S3       = X3_W + 1;
  localparam int K3_W     = S3 - 1;
  localparam int Q3_W     = L3 - 1;
  localparam int P3H_W    = HI3_W + Q3_W;
  localparam int P3X_W    = X3_W + K3_W;
  localparam logic [Q3_W-1:0] Q3 = Q3_W'((64'd1 << L3) / 64'd3);
  localparam logic [1:0]      R3 = 2'((64'd1 << L3) % 64'd3);
  localparam logic [K3_W-1:0] K3 = K3_W'(((64'd1 << S3) + 64'd2) / 64'd3);

  typedef struct packed {
    sample_t sample_m2;
    sample_t sample_m1;
    sample_t sample_c;
    sample_t sample_p1;
    sample_t sample_p2;
  } in_t;

  typedef struct packed {
    sample_t interface_value;
    logic    limiter_applied;
  } out_t;

  typedef struct packed {
    wide_t lin_sum;
    wide_t d2m;
    wide_t d2;
    wide_t d2p;
    wide_t fmp;
    wide_t ful;
    wide_t fav;
    wide_t h3;
    wide_t c;
    wide_t ap1;
  } s1_t;

  typedef struct packed {
    logic              neg60;
    logic [P15H_W-1:0] p60_hi;
    logic [P15X_W-1:0] p60_x;
    wide_t             dmp;
    wide_t             dmm;
    wide_t             fmp;
    wide_t             ful;
    wide_t             fav;
    wide_t             h3;
    wide_t             c;
    wide_t             ap1;
  } s2_t;

  typedef struct packed {
    wide_t            f;
    logic             neg3;
    logic [P3H_W-1:0] p3_hi;
    logic [P3X_W-1:0] p3_x;
    wide_t            fmd;
    wide_t            fmp;
    wide_t            ful;
    wide_t            h3;
    wide_t            c;
    wide_t            ap1;
  } s3_t;

  typedef struct packed {
    wide_t            f;
    wide_t            flc;
    wide_t            fmd;
    wide_t            ful;
    wide_t            c;
    wide_t            ap1;
    logic [THR_W-1:0] ua;
    logic [THR_W-1:0] ub;
    logic             trivial;
    logic             small_ab;
  } s4_t;

  typedef struct packed {
    wide_t f;
    wide_t fmin;
    wide_t fmax;
    logic  accept;
  } s5_t;

  function automatic wide_t wext(input sample_t s);
    return wide_t'(s);
  endfunction

  function automatic wide_t half(input wide_t x);
    return x >>> 1;
  endfunction

  function automatic wide_t wmin(input wide_t a, input wide_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic wide_t wmax(input wide_t a, input wide_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic wide_t minmod(input wide_t a, input wide_t b);
    wide_t r;
    if (a > WIDE_ZERO && b > WIDE_ZERO) begin
      r = wmin(a, b);
    end else if (a < WIDE_ZERO && b < WIDE_ZERO) begin
      r = wmax(a, b);
    end else begin
      r = WIDE_ZERO;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mp5_interface_reconstruct.sv =====
`default_nettype none
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------
// input    | in_valid_i / in_stall_o   | in_data_i  : five-sample stencil
// output   | out_valid_o / out_stall_i | out_data_o : interface value, flag
// config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// six register stages, one transaction per cycle sustained while the output is not stalled
// each stage holds one stencil; a stage advances when it is empty or the one
// after it advances, so bubbles close up while the output is stalled
// in_stall_o rises only once all six stages hold a transaction
// reset clears the stage valid bits and loads limiter_gain = 4,
// accept_threshold = 0; stage payload registers are not reset
module mp5_interface_reconstruct import mp5r_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stencil input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  // reconstructed interface value
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  // register write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [GAIN_W-1:0] gain_q;
  logic [THR_W-1:0]  thr_q;

  logic s2_valid, s2_stall;
  s2_t  s2_data;
  logic s4_valid, s4_stall;
  s4_t  s4_data;

  // configuration registers; write only while the pipe is empty (the block does not enforce it)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(4);
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIMITER_GAIN:     gain_q <= cfg_wdata_i[GAIN_W-1:0];
        CFG_ACCEPT_THRESHOLD: thr_q  <= cfg_wdata_i[THR_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // stages 1-2: linear sum, curvatures, divide-by-60 partial products
  mp5r_stencil u_stencil (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (in_data_i),
    .gain_i  (gain_q),
    .valid_o (s2_valid),
    .stall_i (s2_stall),
    .data_o  (s2_data)
  );

  // stages 3-4: linear estimate, large-curvature value, acceptance factors
  mp5r_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .stall_o (s2_stall),
    .data_i  (s2_data),
    .valid_o (s4_valid),
    .stall_i (s4_stall),
    .data_o  (s4_data)
  );

  // stages 5-6: acceptance test, bounds, median clamp, saturation
  mp5r_limit u_limit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_valid),
    .stall_o (s4_stall),
    .data_i  (s4_data),
    .thr_i   (thr_q),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== sv/mp5r_stencil.sv =====
`default_nettype none
module mp5r_stencil import mp5r_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  in_t               data_i,
  input  logic [GAIN_W-1:0] gain_i,
  output logic              valid_o,
  input  logic              stall_i,
  output s2_t               data_o
);

  logic v1_q, v2_q, en1, en2;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;

  wide_t am2, am1, c, ap1, ap2, alpha, up;
  wide_t mag;
  logic [DIV_W-1:0] m60;
  logic [M4_W-1:0]  m4;
  logic [HI_W-1:0]  hi;
  logic [LO_W-1:0]  lo;
  logic [X15_W-1:0] x15;
  wide_t t1p, t2p, t1m, t2m;

  assign en2     = !v2_q || !stall_i;
  assign en1     = !v1_q || en2;
  assign stall_o = !en1;

  // stage 1: linear sum, curvatures, bound and upper values
  always_comb begin
    am2   = wext(data_i.sample_m2);
    am1   = wext(data_i.sample_m1);
    c     = wext(data_i.sample_c);
    ap1   = wext(data_i.sample_p1);
    ap2   = wext(data_i.sample_p2);
    alpha = wide_t'(gain_i);
    up    = alpha * (c - am1);
    s1_d.lin_sum = (am2 <<< 1) - COEF_M1 * am1 + COEF_C * c + COEF_P1 * ap1 - COEF_P2 * ap2;
    s1_d.d2m     = am2 + c - (am1 <<< 1);
    s1_d.d2      = am1 + ap1 - (c <<< 1);
    s1_d.d2p     = c + ap2 - (ap1 <<< 1);
    s1_d.fmp     = c + minmod(ap1 - c, up);
    s1_d.ful     = c + up;
    s1_d.fav     = half(c + ap1);
    s1_d.h3      = half((c <<< 1) + c - am1);
    s1_d.c       = c;
    s1_d.ap1     = ap1;
  end

  // stage 2: divide-by-60 partial products, limited curvatures
  always_comb begin
    mag = s1_q.lin_sum[WIDE_W-1] ? -s1_q.lin_sum : s1_q.lin_sum;
    m60 = mag[DIV_W-1:0] + DIV_W'(ROUND60);
    m4  = m60[DIV_W-1:2];
    hi  = m4[M4_W-1:LO_W];
    lo  = m4[LO_W-1:0];
    x15 = X15_W'(hi) * X15_W'(R15) + X15_W'(lo);
    t1p = minmod((s1_q.d2 <<< 2) - s1_q.d2p, (s1_q.d2p <<< 2) - s1_q.d2);
    t2p = minmod(s1_q.d2, s1_q.d2p);
    t1m = minmod((s1_q.d2m <<< 2) - s1_q.d2, (s1_q.d2 <<< 2) - s1_q.d2m);
    t2m = minmod(s1_q.d2, s1_q.d2m);
    s2_d.neg60  = s1_q.lin_sum[WIDE_W-1];
    s2_d.p60_hi = P15H_W'(hi) * P15H_W'(Q15);
    s2_d.p60_x  = P15X_W'(x15) * P15X_W'(K15);
    s2_d.dmp    = minmod(t1p, t2p);
    s2_d.dmm    = minmod(t1m, t2m);
    s2_d.fmp    = s1_q.fmp;
    s2_d.ful    = s1_q.ful;
    s2_d.fav    = s1_q.fav;
    s2_d.h3     = s1_q.h3;
    s2_d.c      = s1_q.c;
    s2_d.ap1    = s1_q.ap1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
  end

  assign valid_o = v2_q;
  assign data_o  = s2_q;

endmodule
`default_nettype wire

// ===== sv/mp5r_divide.sv =====
`default_nettype none
module mp5r_divide import mp5r_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic stall_o,
  input  s2_t  data_i,
  output logic valid_o,
  input  logic stall_i,
  output s4_t  data_o
);

  logic v3_q, v4_q, en3, en4;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;

  wide_t q60, n3, mag3, q3, a, b, ua, ub;
  logic [DIV3_W-1:0] m3;
  logic [HI3_W-1:0]  hi3;
  logic [L3-1:0]     lo3;
  logic [X3_W-1:0]   x3;

  assign en4     = !v4_q || !stall_i;
  assign en3     = !v3_q || en4;
  assign stall_o = !en3;

  // stage 3: finish divide by 60, start rounded 4*dmm/3
  always_comb begin
    q60  = wide_t'(data_i.p60_hi) + wide_t'(data_i.p60_x[P15X_W-1:S15]);
    n3   = data_i.dmm <<< 2;
    mag3 = n3[WIDE_W-1] ? -n3 : n3;
    m3   = mag3[DIV3_W-1:0] + DIV3_W'(1);
    hi3  = m3[DIV3_W-1:L3];
    lo3  = m3[L3-1:0];
    x3   = X3_W'(hi3) * X3_W'(R3) + X3_W'(lo3);
    s3_d.f     = data_i.neg60 ? -q60 : q60;
    s3_d.neg3  = n3[WIDE_W-1];
    s3_d.p3_hi = P3H_W'(hi3) * P3H_W'(Q3);
    s3_d.p3_x  = P3X_W'(x3) * P3X_W'(K3);
    s3_d.fmd   = data_i.fav - half(data_i.dmp);
    s3_d.fmp   = data_i.fmp;
    s3_d.ful   = data_i.ful;
    s3_d.h3    = data_i.h3;
    s3_d.c     = data_i.c;
    s3_d.ap1   = data_i.ap1;
  end

  // stage 4: large-curvature value, acceptance factors
  always_comb begin
    q3 = wide_t'(s3_q.p3_hi) + wide_t'(s3_q.p3_x[P3X_W-1:S3]);
    a  = s3_q.f - s3_q.c;
    b  = s3_q.f - s3_q.fmp;
    ua = a[WIDE_W-1] ? -a : a;
    ub = b[WIDE_W-1] ? -b : b;
    s4_d.f        = s3_q.f;
    s4_d.flc      = s3_q.h3 + (s3_q.neg3 ? -q3 : q3);
    s4_d.fmd      = s3_q.fmd;
    s4_d.ful      = s3_q.ful;
    s4_d.c        = s3_q.c;
    s4_d.ap1      = s3_q.ap1;
    s4_d.ua       = ua[THR_W-1:0];
    s4_d.ub       = ub[THR_W-1:0];
    // zero factor or opposite signs always accept
    s4_d.trivial  = (a == WIDE_ZERO) || (b == WIDE_ZERO) || (a[WIDE_W-1] != b[WIDE_W-1]);
    s4_d.small_ab = (ua[WIDE_W-1:THR_W] == '0) && (ub[WIDE_W-1:THR_W] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) v3_q <= valid_i;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) s3_q <= s3_d;
    if (en4 && v3_q) s4_q <= s4_d;
  end

  assign valid_o = v4_q;
  assign data_o  = s4_q;

endmodule
`default_nettype wire

// ===== sv/mp5r_limit.sv =====
`default_nettype none
module mp5r_limit import mp5r_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  s4_t              data_i,
  input  logic [THR_W-1:0] thr_i,
  output logic             valid_o,
  input  logic             stall_i,
  output out_t             data_o
);

  logic v5_q, v6_q, en5, en6;
  s5_t  s5_d, s5_q;
  out_t out_d, out_q;

  logic [PROD_W-1:0] prod;
  wide_t lim, res;

  assign en6     = !v6_q || !stall_i;
  assign en5     = !v5_q || en6;
  assign stall_o = !en5;

  // stage 5: acceptance product, bounds fmin and fmax
  always_comb begin
    prod = PROD_W'(data_i.ua) * PROD_W'(data_i.ub);
    s5_d.f      = data_i.f;
    s5_d.accept = data_i.trivial || (data_i.small_ab && (prod <= PROD_W'(thr_i)));
    s5_d.fmin   = wmax(wmin(wmin(data_i.c, data_i.ap1), data_i.fmd),
                       wmin(wmin(data_i.c, data_i.ful), data_i.flc));
    s5_d.fmax   = wmin(wmax(wmax(data_i.c, data_i.ap1), data_i.fmd),
                       wmax(wmax(data_i.c, data_i.ful), data_i.flc));
  end

  // stage 6: median clamp and saturation
  always_comb begin
    lim = s5_q.f + minmod(s5_q.fmin - s5_q.f, s5_q.fmax - s5_q.f);
    res = s5_q.accept ? s5_q.f : lim;
    if (res > SAT_MAX) begin
      res = SAT_MAX;
    end else if (res < SAT_MIN) begin
      res = SAT_MIN;
    end
    out_d.interface_value = res[SAMPLE_WIDTH-1:0];
    out_d.limiter_applied = !s5_q.accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en5) v5_q <= valid_i;
      if (en6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5 && valid_i) s5_q <= s5_d;
    if (en6 && v5_q) out_q <= out_d;
  end

  assign valid_o = v6_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_mp5_interface_reconstruct.sv =====
`default_nettype none
module tb_mp5_interface_reconstruct;
  import mp5r_pkg::*;

  // pipeline depth given at the head of the block
  localparam int LATENCY         = 6;
  localparam int FRAC            = 16;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES      = 8;
  localparam int PICK_RANDOM     = -1;

  // register indexes past the end of the map, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  localparam longint SMP_MIN = -(longint'(1) << (SAMPLE_WIDTH - 1));
  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam sample_t S_MIN  = sample_t'(SMP_MIN);
  localparam sample_t S_MAX  = sample_t'(SMP_MAX);
  localparam sample_t S_ONE  = sample_t'(longint'(1) << FRAC);

  // which sides insert bubbles during a phase
  typedef enum int {IDLE_BOTH, IDLE_NONE, IDLE_RX_ONLY, IDLE_TX_ONLY} idle_mode_e;

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } vec_t;

  // dut signals, inputs driven to known values from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // shadow copy of the two registers, reset values
  logic [GAIN_W-1:0] gain_q = 4'd4;
  logic [THR_W-1:0]  eps_q  = '0;

  out_t pending_iface[$];   // interface values still owed by the block
  vec_t vectors[$];         // directed stencil table
  int   mismatches = 0;
  bit   tx_idle_en = 1'b1;
  bit   rx_idle_en = 1'b1;
  int   stall_left = 0;

  mp5_interface_reconstruct u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // arithmetic helpers for the predictor, all in 64-bit signed
  // ---------------------------------------------------------------------

  // round to nearest, ties away from zero
  function automatic longint rdiv(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint minmod64(input longint a, input longint b);
    if (a > 0 && b > 0) return (a < b) ? a : b;
    if (a < 0 && b < 0) return (a > b) ? a : b;
    return 0;
  endfunction

  function automatic longint min64(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint max64(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  // exact test of a*b <= eps without a wide multiply
  function automatic bit within_eps(input longint a, input longint b);
    longint unsigned ua, ub;
    if (a == 0 || b == 0) return 1'b1;
    if ((a < 0) != (b < 0)) return 1'b1;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return ub <= (longint'(eps_q) / ua);
  endfunction

  // mp5 right-interface value for one stencil under the current registers
  function automatic out_t predict_iface(input in_t s);
    longint am2, am1, c, ap1, ap2, alpha, f, fmp;
    longint d2m, d2, d2p, t1, t2, dmp, dmm;
    longint ful, fav, fmd, flc, fmin, fmax;
    out_t   r;
    am2   = longint'(s.sample_m2);
    am1   = longint'(s.sample_m1);
    c     = longint'(s.sample_c);
    ap1   = longint'(s.sample_p1);
    ap2   = longint'(s.sample_p2);
    alpha = longint'(gain_q);
    r.limiter_applied = 1'b0;

    // fifth-order linear estimate and monotonicity bound
    f   = rdiv(2 * am2 - 13 * am1 + 47 * c + 27 * ap1 - 3 * ap2, 60);
    fmp = c + minmod64(ap1 - c, alpha * (c - am1));

    if (!within_eps(f - c, f - fmp)) begin
      r.limiter_applied = 1'b1;
      d2m = am2 + c - 2 * am1;
      d2  = am1 + ap1 - 2 * c;
      d2p = c + ap2 - 2 * ap1;

      t1  = minmod64(4 * d2 - d2p, 4 * d2p - d2);
      t2  = minmod64(d2, d2p);
      dmp = minmod64(t1, t2);
      t1  = minmod64(4 * d2m - d2, 4 * d2 - d2m);
      t2  = minmod64(d2, d2m);
      dmm = minmod64(t1, t2);

      ful = c + alpha * (c - am1);
      fav = (c + ap1) >>> 1;
      fmd = fav - (dmp >>> 1);
      flc = ((3 * c - am1) >>> 1) + rdiv(4 * dmm, 3);

      fmin = max64(min64(min64(c, ap1), fmd), min64(min64(c, ful), flc));
      fmax = min64(max64(max64(c, ap1), fmd), max64(max64(c, ful), flc));
      f    = f + minmod64(fmin - f, fmax - f);
    end

    if (f < SMP_MIN) f = SMP_MIN;
    if (f > SMP_MAX) f = SMP_MAX;
    r.interface_value = sample_t'(f);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  // mostly short bubbles, now and then a long one
  function automatic int pick_gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint srand(input longint mag);
    return longint'($urandom_range(0, 2 * mag)) - mag;
  endfunction

  // random stencil: smooth ramps with noise dominate so that both the
  // accept path and the limiter are exercised, the rest are steps,
  // corner values and raw noise
  function automatic in_t random_stencil();
    longint  base, slope, mag;
    longint  v[5];
    sample_t corners[6];
    sample_t lvl_a, lvl_b;
    int      style, cut;
    corners = '{S_MIN, S_MAX, sample_t'(0), sample_t'(-1), sample_t'(1), S_ONE};
    style = $urandom_range(0, 9);
    if (style <= 5) begin
      base  = longint'($signed($urandom)) >>> 1;
      mag   = longint'(1) << $urandom_range(0, 20);
      slope = srand(mag);
      mag   = mag >> $urandom_range(0, 6);
      for (int i = 0; i < 5; i++) v[i] = base + slope * (i - 2) + srand(mag);
    end else if (style == 6) begin
      // discontinuity somewhere inside the stencil
      lvl_a = sample_t'($urandom);
      lvl_b = sample_t'($urandom);
      cut   = $urandom_range(1, 4);
      for (int i = 0; i < 5; i++) v[i] = (i < cut) ? lvl_a : lvl_b;
    end else if (style == 7) begin
      for (int i = 0; i < 5; i++) v[i] = corners[$urandom_range(0, 5)];
    end else begin
      for (int i = 0; i < 5; i++) v[i] = longint'($signed($urandom));
    end
    return {sample_t'(v[0]), sample_t'(v[1]), sample_t'(v[2]),
            sample_t'(v[3]), sample_t'(v[4])};
  endfunction

  task automatic add_vec(input sample_t m2, input sample_t m1, input sample_t c,
                         input sample_t p1, input sample_t p2, input bit typed,
                         input sample_t want_val, input logic want_flag);
    vec_t r;
    r.stim  = {m2, m1, c, p1, p2};
    r.typed = typed;
    r.want  = {want_val, want_flag};
    vectors.push_back(r);
  endtask

  // one register write, entered and left at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_LIMITER_GAIN) gain_q = val[GAIN_W-1:0];
    else if (idx == CFG_ACCEPT_THRESHOLD) eps_q = val[THR_W-1:0];
  endtask

  // one stencil transaction, entered and left at a falling edge;
  // the expectation is queued at the falling edge after acceptance
  task automatic send_stencil(input in_t s, input out_t want);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap_len() : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = s;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    pending_iface.push_back(want);
    in_valid_i = 1'b0;
  endtask

  // hold the input until every result is back, then let the pipe empty
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_iface.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // receiver: random stall bursts
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      out_stall_i = 1'b1;
      stall_left  = pick_gap_len() - 1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // output checker: every transaction against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_iface.size() == 0) begin
        $error("output transaction with nothing expected: %h", out_data_o);
        mismatches++;
      end else begin
        want = pending_iface.pop_front();
        if (out_data_o.interface_value !== want.interface_value) begin
          $error("interface_value: expected %0d, got %0d",
                 want.interface_value, out_data_o.interface_value);
          mismatches++;
        end
        if (out_data_o.limiter_applied !== want.limiter_applied) begin
          $error("limiter_applied: expected %0b, got %0b",
                 want.limiter_applied, out_data_o.limiter_applied);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int         ph_gain[NUM_PHASES];
    int         ph_eps[NUM_PHASES];
    idle_mode_e ph_idle[NUM_PHASES];
    in_t        s;
    out_t       want;
    logic [CFG_DATA_W-1:0] wd;

    // register settings per phase, extremes included; gain 0 and gains
    // above 8 are legal and pass through unchanged
    ph_gain = '{4, 1, 8, 0, 15, PICK_RANDOM, 2, PICK_RANDOM};
    ph_eps  = '{0, 65535, 100, 0, 65535, PICK_RANDOM, 1000, PICK_RANDOM};
    ph_idle = '{IDLE_BOTH, IDLE_NONE, IDLE_BOTH, IDLE_RX_ONLY,
                IDLE_TX_ONLY, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};

    // directed table, reset register values apply
    // flat stencils reproduce themselves exactly and are accepted
    add_vec(0, 0, 0, 0, 0, 1, 0, 1'b0);
    add_vec(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 1, S_MAX, 1'b0);
    add_vec(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 1, S_MIN, 1'b0);
    add_vec(-1, -1, -1, -1, -1, 1, -1, 1'b0);
    add_vec(S_ONE, S_ONE, S_ONE, S_ONE, S_ONE, 1, S_ONE, 1'b0);
    // steps, spikes and full-scale swings, predicted
    add_vec(0, 0, 0, S_MAX, S_MAX, 0, 0, 1'b0);
    add_vec(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, 0, 0, 1'b0);
    add_vec(S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, 0, 0, 1'b0);
    add_vec(S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 0, 0, 1'b0);
    add_vec(0, 0, S_MAX, 0, 0, 0, 0, 1'b0);
    add_vec(0, 0, S_MIN, 0, 0, 0, 0, 1'b0);
    // large upwind slope drives the upper limit past the sample range
    add_vec(S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 0, 0, 1'b0);
    add_vec(S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 0, 0, 1'b0);
    add_vec(S_MAX, 0, S_MIN, 0, S_MAX, 0, 0, 1'b0);
    // smooth ramps, opposite-sign acceptance factors
    add_vec(S_ONE, 2 * S_ONE, 3 * S_ONE, 4 * S_ONE, 5 * S_ONE, 0, 0, 1'b0);
    add_vec(0, -S_ONE, 0, S_ONE, 0, 0, 0, 1'b0);
    add_vec(S_ONE, 2 * S_ONE, 4 * S_ONE, 8 * S_ONE, 16 * S_ONE, 0, 0, 1'b0);
    add_vec(-3 * S_ONE, -2 * S_ONE, -S_ONE, 0, S_ONE, 0, 0, 1'b0);
    // bit patterns and tiny values
    add_vec(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
            32'h5555_5555, 0, 0, 1'b0);
    add_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
            32'hAAAA_AAAA, 0, 0, 1'b0);
    add_vec(1, 0, 1, 2, 1, 0, 0, 1'b0);
    add_vec(0, 1, 3, 2, -1, 0, 0, 1'b0);

    // hold reset, then release at a falling edge
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // writes to unmapped indexes leave both registers untouched
    write_reg(CFG_IDX_SPARE2, '1);
    write_reg(CFG_IDX_SPARE3, '1);

    foreach (vectors[i]) begin
      want = vectors[i].typed ? vectors[i].want : predict_iface(vectors[i].stim);
      send_stencil(vectors[i].stim, want);
    end
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only with the pipe empty; upper data bits of the
      // gain write are junk and must be dropped
      wd = CFG_DATA_W'($urandom);
      wd[GAIN_W-1:0] = (ph_gain[ph] == PICK_RANDOM) ? GAIN_W'($urandom)
                                                    : GAIN_W'(ph_gain[ph]);
      write_reg(CFG_LIMITER_GAIN, wd);
      wd = (ph_eps[ph] == PICK_RANDOM) ? CFG_DATA_W'($urandom)
                                       : CFG_DATA_W'(ph_eps[ph]);
      write_reg(CFG_ACCEPT_THRESHOLD, wd);

      tx_idle_en = (ph_idle[ph] == IDLE_BOTH) || (ph_idle[ph] == IDLE_TX_ONLY);
      rx_idle_en = (ph_idle[ph] == IDLE_BOTH) || (ph_idle[ph] == IDLE_RX_ONLY);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // one full drain in the middle of a stalled phase
        if (ph == 2 && k == ITEMS_PER_PHASE / 2) wait_idle();
        s = random_stencil();
        send_stencil(s, predict_iface(s));
      end
      wait_idle();
    end

    repeat (LATENCY + 4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
